@@ hw/rtl/lce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types, constants and the brightness table of the LED color effect
// engine.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int PHASE_STEPS = 256;
  localparam int PHASE_BITS  = $clog2(PHASE_STEPS);
  localparam int COLOR_BITS  = 8;
  localparam int DUR_BITS    = 16;
  localparam int RGB_BITS    = 3 * COLOR_BITS;
  // quotient bits of the shared divider: phase or one color component
  localparam int DIV_BITS    = (PHASE_BITS > COLOR_BITS) ? PHASE_BITS : COLOR_BITS;
  localparam int STEP_W      = $clog2(DIV_BITS + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SET   = 2'd1,
    OP_FADE  = 2'd2,
    OP_TRANS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_FADE   = 2'd1,
    MODE_TRANS  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    COMP_RED   = 2'd0,
    COMP_GREEN = 2'd1,
    COMP_BLUE  = 2'd2
  } comp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PROD,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_SCALE,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_DECODE,
    DP_PROD,
    DP_LOAD,
    DP_DIV,
    DP_STORE,
    DP_SCALE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    comp_t  comp;
  } dp_cmd_t;

  typedef struct packed {
    op_t   op;
    mode_t mode;
    logic  tick_done;
    logic  out_busy;
  } dp_status_t;

  // brightness table, built at elaboration
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef logic [COLOR_BITS-1:0] bright_rom_t [0:PHASE_STEPS-1];

  function automatic longint cos_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    // each term x^2n / (2n)! follows from the one before, signs alternate
    term = ((term * x2) >> 30) / 64'd2;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd132;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd182;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd240;
    sum  = sum + longint'(term);
    return sum;
  endfunction

  function automatic bright_rom_t build_rom();
    bright_rom_t     rom;
    longint unsigned m;
    longint unsigned x;
    longint          c;
    longint          b;
    longint unsigned v;
    for (int k = 0; k < PHASE_STEPS; k++) begin
      m = (2 * k <= PHASE_STEPS) ? longint'(k) : longint'(PHASE_STEPS - k);
      x = (2 * PI_Q30 * m) / PHASE_STEPS;
      if (2 * x > PI_Q30) begin
        c = -cos_q30(PI_Q30 - x);
      end else begin
        c = cos_q30(x);
      end
      b = (longint'(Q30_ONE) - c) / 2;
      if (b < 0) begin
        b = 0;
      end
      if (b > longint'(Q30_ONE)) begin
        b = longint'(Q30_ONE);
      end
      v = (longint'(b) * 255 + (64'd1 << 29)) >> 30;
      rom[k] = v[COLOR_BITS-1:0];
    end
    return rom;
  endfunction

  localparam bright_rom_t BRIGHT_ROM = build_rom();

endpackage
`default_nettype wire

@@ hw/rtl/lce_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lce_ctrl
// Sequencer of the effect engine: takes one beat, walks the datapath through
// decode, products, division steps or scaling as needed and emits any result.
// ----------------------------------------------------------------------------
module lce_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lce_pkg::dp_status_t status,
  output lce_pkg::dp_cmd_t        cmd
);

  lce_pkg::ctrl_state_t         state_r, state_nxt;
  logic [lce_pkg::STEP_W-1:0]   step_r, step_nxt;
  lce_pkg::comp_t               comp_r, comp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lce_pkg::ST_IDLE;
      step_r  <= '0;
      comp_r  <= lce_pkg::COMP_RED;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      comp_r  <= comp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    comp_nxt  = comp_r;
    in_ready  = 1'b0;
    cmd.op    = lce_pkg::DP_NOP;
    cmd.comp  = comp_r;
    case (state_r)
      lce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = lce_pkg::DP_CAPTURE;
          state_nxt = lce_pkg::ST_DECODE;
        end
      end
      lce_pkg::ST_DECODE: begin
        cmd.op = lce_pkg::DP_DECODE;
        case (status.op)
          lce_pkg::OP_SET: state_nxt = lce_pkg::ST_EMIT;
          lce_pkg::OP_TICK: begin
            if (status.mode == lce_pkg::MODE_FADE) begin
              state_nxt = lce_pkg::ST_LOAD;
            end else if (status.mode == lce_pkg::MODE_TRANS) begin
              comp_nxt  = lce_pkg::COMP_RED;
              state_nxt = status.tick_done ? lce_pkg::ST_EMIT : lce_pkg::ST_PROD;
            end else begin
              state_nxt = lce_pkg::ST_IDLE;
            end
          end
          default: state_nxt = lce_pkg::ST_IDLE;
        endcase
      end
      lce_pkg::ST_PROD: begin
        cmd.op    = lce_pkg::DP_PROD;
        state_nxt = lce_pkg::ST_LOAD;
      end
      lce_pkg::ST_LOAD: begin
        cmd.op    = lce_pkg::DP_LOAD;
        step_nxt  = (status.mode == lce_pkg::MODE_FADE) ?
                    lce_pkg::STEP_W'(lce_pkg::PHASE_BITS) :
                    lce_pkg::STEP_W'(lce_pkg::COLOR_BITS);
        state_nxt = lce_pkg::ST_DIV;
      end
      lce_pkg::ST_DIV: begin
        cmd.op   = lce_pkg::DP_DIV;
        step_nxt = step_r - 1'b1;
        if (step_r == lce_pkg::STEP_W'(1)) begin
          state_nxt = lce_pkg::ST_STORE;
        end
      end
      lce_pkg::ST_STORE: begin
        cmd.op = lce_pkg::DP_STORE;
        if (status.mode == lce_pkg::MODE_FADE) begin
          state_nxt = lce_pkg::ST_SCALE;
        end else if (comp_r == lce_pkg::COMP_BLUE) begin
          state_nxt = lce_pkg::ST_EMIT;
        end else begin
          // advance to the next color component
          comp_nxt  = lce_pkg::comp_t'(comp_r + 2'd1);
          state_nxt = lce_pkg::ST_PROD;
        end
      end
      lce_pkg::ST_SCALE: begin
        cmd.op    = lce_pkg::DP_SCALE;
        state_nxt = lce_pkg::ST_EMIT;
      end
      lce_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.op    = lce_pkg::DP_EMIT;
          state_nxt = lce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lce_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/lce_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lce_datapath
// Effect state, elapsed counter, restoring divider, brightness scaling and
// the output register of the effect engine.
// ----------------------------------------------------------------------------
module lce_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lce_pkg::dp_cmd_t                  cmd,
  output lce_pkg::dp_status_t                    status,
  input  wire lce_pkg::op_t                      in_op,
  input  wire logic [lce_pkg::RGB_BITS-1:0]      in_color,
  input  wire logic [lce_pkg::DUR_BITS-1:0]      in_dur,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [lce_pkg::RGB_BITS-1:0]           out_color
);

  localparam int CB = lce_pkg::COLOR_BITS;
  localparam int DB = lce_pkg::DUR_BITS;
  localparam int RB = lce_pkg::RGB_BITS;
  localparam int QW = lce_pkg::DIV_BITS;
  localparam int PB = lce_pkg::PHASE_BITS;

  function automatic logic [CB-1:0] get_comp(input logic [RB-1:0] color,
                                             input lce_pkg::comp_t comp);
    logic [CB-1:0] v;
    case (comp)
      lce_pkg::COMP_RED:   v = color[3*CB-1:2*CB];
      lce_pkg::COMP_GREEN: v = color[2*CB-1:CB];
      default:             v = color[CB-1:0];
    endcase
    return v;
  endfunction

  // floor(t * lvl / 255), exact for 16-bit products
  function automatic logic [CB-1:0] scale(input logic [CB-1:0] t,
                                          input logic [CB-1:0] lvl);
    logic [2*CB-1:0] p;
    logic [2*CB:0]   s;
    p = t * lvl;
    s = {1'b0, p} + {{(CB+1){1'b0}}, p[2*CB-1:CB]} + 1'b1;
    return s[2*CB-1:CB];
  endfunction

  lce_pkg::op_t     op_r, op_nxt;
  logic [RB-1:0]    col_r, col_nxt;
  logic [DB-1:0]    dur_r, dur_nxt;
  lce_pkg::mode_t   mode_r, mode_nxt;
  logic [RB-1:0]    target_r, target_nxt;
  logic [RB-1:0]    start_r, start_nxt;
  logic [RB-1:0]    shown_r, shown_nxt;
  logic [DB-1:0]    len_r, len_nxt;
  logic [DB-1:0]    elapsed_r, elapsed_nxt;
  logic [RB-1:0]    res_r, res_nxt;
  logic [RB-1:0]    prod_a_r, prod_a_nxt;
  logic [RB-1:0]    prod_b_r, prod_b_nxt;
  logic [DB-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    lo_r, lo_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CB-1:0]    level_r, level_nxt;
  logic [RB-1:0]    out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [DB-1:0]    e_inc;
  logic             tick_done;
  logic [DB:0]      rem2;
  logic [DB:0]      rem_sub;
  logic             ge;
  logic [RB-1:0]    num;
  logic [PB-1:0]    phase;

  assign e_inc     = (elapsed_r == {DB{1'b1}}) ? elapsed_r : elapsed_r + 1'b1;
  assign tick_done = (e_inc >= len_r);

  assign rem2    = {rem_r, lo_r[QW-1]};
  assign rem_sub = rem2 - {1'b0, len_r};
  assign ge      = (rem2 >= {1'b0, len_r});
  assign num     = prod_a_r + prod_b_r;
  assign phase   = (len_r == '0) ? '0 : quo_r[PB-1:0];

  assign status.op        = op_r;
  assign status.mode      = mode_r;
  assign status.tick_done = tick_done;
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_color = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lce_pkg::MODE_STATIC;
      target_r    <= '0;
      start_r     <= '0;
      shown_r     <= '0;
      len_r       <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      target_r    <= target_nxt;
      start_r     <= start_nxt;
      shown_r     <= shown_nxt;
      len_r       <= len_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    col_r      <= col_nxt;
    dur_r      <= dur_nxt;
    res_r      <= res_nxt;
    prod_a_r   <= prod_a_nxt;
    prod_b_r   <= prod_b_nxt;
    rem_r      <= rem_nxt;
    lo_r       <= lo_nxt;
    quo_r      <= quo_nxt;
    level_r    <= level_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    op_nxt        = op_r;
    col_nxt       = col_r;
    dur_nxt       = dur_r;
    mode_nxt      = mode_r;
    target_nxt    = target_r;
    start_nxt     = start_r;
    shown_nxt     = shown_r;
    len_nxt       = len_r;
    elapsed_nxt   = elapsed_r;
    res_nxt       = res_r;
    prod_a_nxt    = prod_a_r;
    prod_b_nxt    = prod_b_r;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    quo_nxt       = quo_r;
    level_nxt     = level_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op)
      lce_pkg::DP_CAPTURE: begin
        op_nxt  = in_op;
        col_nxt = in_color;
        dur_nxt = in_dur;
      end
      lce_pkg::DP_DECODE: begin
        case (op_r)
          lce_pkg::OP_SET: begin
            target_nxt = col_r;
            mode_nxt   = lce_pkg::MODE_STATIC;
            res_nxt    = col_r;
          end
          lce_pkg::OP_FADE: begin
            target_nxt  = col_r;
            len_nxt     = dur_r;
            elapsed_nxt = '0;
            mode_nxt    = lce_pkg::MODE_FADE;
          end
          lce_pkg::OP_TRANS: begin
            start_nxt   = shown_r;
            target_nxt  = col_r;
            len_nxt     = dur_r;
            elapsed_nxt = '0;
            mode_nxt    = lce_pkg::MODE_TRANS;
          end
          default: begin
            if (mode_r == lce_pkg::MODE_FADE) begin
              // restart the period once the length is reached
              elapsed_nxt = tick_done ? '0 : e_inc;
            end else if (mode_r == lce_pkg::MODE_TRANS) begin
              elapsed_nxt = e_inc;
              if (tick_done) begin
                mode_nxt = lce_pkg::MODE_STATIC;
                res_nxt  = target_r;
              end
            end
          end
        endcase
      end
      lce_pkg::DP_PROD: begin
        prod_a_nxt = get_comp(start_r, cmd.comp) * (len_r - elapsed_r);
        prod_b_nxt = get_comp(target_r, cmd.comp) * elapsed_r;
      end
      lce_pkg::DP_LOAD: begin
        quo_nxt = '0;
        if (mode_r == lce_pkg::MODE_FADE) begin
          rem_nxt = elapsed_r;
          lo_nxt  = '0;
        end else begin
          // upper part of the numerator is below the length
          rem_nxt = num[RB-1:CB];
          lo_nxt  = QW'(num[CB-1:0]) << (QW - CB);
        end
      end
      lce_pkg::DP_DIV: begin
        rem_nxt = ge ? rem_sub[DB-1:0] : rem2[DB-1:0];
        quo_nxt = {quo_r[QW-2:0], ge};
        lo_nxt  = lo_r << 1;
      end
      lce_pkg::DP_STORE: begin
        if (mode_r == lce_pkg::MODE_FADE) begin
          level_nxt = lce_pkg::BRIGHT_ROM[phase];
        end else begin
          case (cmd.comp)
            lce_pkg::COMP_RED:   res_nxt[3*CB-1:2*CB] = quo_r[CB-1:0];
            lce_pkg::COMP_GREEN: res_nxt[2*CB-1:CB]   = quo_r[CB-1:0];
            default:             res_nxt[CB-1:0]      = quo_r[CB-1:0];
          endcase
        end
      end
      lce_pkg::DP_SCALE: begin
        res_nxt = {scale(target_r[3*CB-1:2*CB], level_r),
                   scale(target_r[2*CB-1:CB], level_r),
                   scale(target_r[CB-1:0], level_r)};
      end
      lce_pkg::DP_EMIT: begin
        shown_nxt     = res_r;
        out_data_nxt  = res_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/led_color_effect_engine_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// led_color_effect_engine_top
// Breathing fade and linear crossfade generator for one color on all pixels.
// Set static, a fade tick and a transition tick give a result; other beats give
// none. A fade tick runs one division and a scaling step, a transition tick one
// division per color component; set static and the tick that ends a transition
// go straight to the output. One beat at a time: the next beat is taken once
// the last is done; a result waits while the output register is still full.
// Synchronous active-low reset: static mode, all colors black.
// ----------------------------------------------------------------------------
module led_color_effect_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // red[7:0], green[15:8], blue[23:16], duration_ms[39:24]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // red_out[7:0], green_out[15:8], blue_out[23:16]
);

  lce_pkg::dp_cmd_t               cmd;
  lce_pkg::dp_status_t            status;
  logic [lce_pkg::RGB_BITS-1:0]   in_color;
  logic [lce_pkg::RGB_BITS-1:0]   out_color;

  // internal color word keeps red in the top byte
  assign in_color = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
  assign out_tdata = {out_color[7:0], out_color[15:8], out_color[23:16]};

  lce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lce_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_op     (lce_pkg::op_t'(in_tuser)),
    .in_color  (in_color),
    .in_dur    (in_tdata[39:24]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_color (out_color)
  );

endmodule
`default_nettype wire

@@ test/tb_led_color_effect_engine_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_color_effect_engine_top
// Self-checking bench for the LED color effect engine. A queue of command and
// tick beats feeds a clocked stream driver. An effect predictor with its own
// brightness table computes the expected color for each accepted beat that
// shows one. A clocked monitor compares every output beat with the oldest
// expected color. Idle patterns on both sides change over the run, and a long
// receiver stall plus drain pauses put pressure on the handshake.
// ----------------------------------------------------------------------------
module tb_led_color_effect_engine_top;
  import lce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned HOLD_AT     = 250;
  localparam int unsigned RANDOM_LIVE = 1600;
  localparam int unsigned MAX_REPORTS = 10;

  localparam longint          UNIT_Q30      = 64'sd1073741824;
  localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    op_t         op;
    rgb_t        col;
    logic [15:0] dur;
    logic        drain;   // hold this beat until no color is outstanding
  } cmd_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // red[7:0], green[15:8], blue[23:16], duration_ms[39:24]
  logic [1:0]  in_tuser   = '0;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // red_out[7:0], green_out[15:8], blue_out[23:16]

  led_color_effect_engine_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // effect state as the predictor sees it
  mode_t       eff_mode;
  rgb_t        tgt;
  rgb_t        origin;
  rgb_t        lit;
  logic [15:0] span;
  logic [15:0] clock_ms;
  logic [7:0]  glow_lut [PHASE_STEPS];

  cmd_beat_t   pending_q [$];
  rgb_t        color_expect_q [$];
  cmd_beat_t   cur_beat;
  rgb_t        want;
  rgb_t        got;

  int unsigned beats_in     = 0;
  int unsigned total_beats  = 0;
  int unsigned results_ok   = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned n_set        = 0;
  int unsigned n_fade       = 0;
  int unsigned n_trans      = 0;
  int unsigned n_live_ticks = 0;
  int unsigned send_idle_pct;
  int unsigned rcv_idle_pct;

  // cosine in Q2.30 on [0, pi/2], Taylor series up to the x^16 term
  function automatic longint taylor_cos(longint unsigned ang);
    longint unsigned sq;
    longint unsigned t;
    longint          acc;
    bit              neg;
    sq  = (ang * ang) >> 30;
    t   = UNIT_Q30;
    acc = UNIT_Q30;
    neg = 1'b1;
    for (int n = 1; n <= 8; n++) begin
      t = (t * sq) >> 30;
      t = t / (4 * n * n - 2 * n);
      acc = neg ? acc - longint'(t) : acc + longint'(t);
      neg = !neg;
    end
    return acc;
  endfunction

  function automatic void fill_glow_lut();
    longint unsigned fold;
    longint unsigned ang;
    longint unsigned v;
    longint          c;
    longint          lvl;
    for (int k = 0; k < PHASE_STEPS; k++) begin
      fold = (2 * k <= PHASE_STEPS) ? k : PHASE_STEPS - k;
      ang  = (2 * HALF_TURN_Q30 * fold) / PHASE_STEPS;
      // past a quarter turn use cos(pi - x) = -cos(x)
      if (2 * ang > HALF_TURN_Q30) begin
        c = -taylor_cos(HALF_TURN_Q30 - ang);
      end else begin
        c = taylor_cos(ang);
      end
      lvl = (UNIT_Q30 - c) / 2;
      if (lvl < 0) begin
        lvl = 0;
      end
      if (lvl > UNIT_Q30) begin
        lvl = UNIT_Q30;
      end
      v = (unsigned'(lvl) * 255 + (64'd1 << 29)) >> 30;
      glow_lut[k] = v[7:0];
    end
  endfunction

  function automatic logic [7:0] dim_ch(logic [7:0] c, logic [7:0] lvl);
    int unsigned p;
    p = int'(c) * int'(lvl);
    return 8'(p / 255);
  endfunction

  function automatic logic [7:0] ramp_ch(logic [7:0] a, logic [7:0] b, logic [15:0] len,
                                         logic [15:0] el);
    int unsigned p;
    p = int'(a) * (int'(len) - int'(el)) + int'(b) * int'(el);
    return 8'(p / int'(len));
  endfunction

  function automatic void show_color(rgb_t c);
    lit = c;
    color_expect_q.push_back(c);
  endfunction

  function automatic void advance_effect(cmd_beat_t cb);
    int         ph;
    logic [7:0] lvl;
    rgb_t       c;
    case (cb.op)
      OP_SET: begin
        n_set++;
        tgt      = cb.col;
        eff_mode = MODE_STATIC;
        show_color(cb.col);
      end
      OP_FADE, OP_TRANS: begin
        if (cb.op == OP_TRANS) begin
          origin = lit;
          eff_mode = MODE_TRANS;
          n_trans++;
        end else begin
          eff_mode = MODE_FADE;
          n_fade++;
        end
        tgt      = cb.col;
        span     = cb.dur;
        clock_ms = '0;
      end
      OP_TICK: begin
        // only a running effect advances on a tick
        if (eff_mode == MODE_FADE || eff_mode == MODE_TRANS) begin
          n_live_ticks++;
          if (clock_ms != 16'hFFFF) begin
            clock_ms = clock_ms + 16'd1;
          end
          if (eff_mode == MODE_FADE) begin
            if (clock_ms >= span) begin
              clock_ms = '0;
            end
            ph = 0;
            if (span != 0) begin
              ph = (int'(clock_ms) * PHASE_STEPS) / int'(span);
            end
            if (ph >= PHASE_STEPS) begin
              ph = PHASE_STEPS - 1;
            end
            lvl = glow_lut[ph];
            c.r = dim_ch(tgt.r, lvl);
            c.g = dim_ch(tgt.g, lvl);
            c.b = dim_ch(tgt.b, lvl);
            show_color(c);
          end else if (clock_ms >= span) begin
            eff_mode = MODE_STATIC;
            show_color(tgt);
          end else begin
            c.r = ramp_ch(origin.r, tgt.r, span, clock_ms);
            c.g = ramp_ch(origin.g, tgt.g, span, clock_ms);
            c.b = ramp_ch(origin.b, tgt.b, span, clock_ms);
            show_color(c);
          end
        end
      end
    endcase
  endfunction

  // ---- stimulus generation ----

  function automatic void queue_beat(op_t op, rgb_t col, logic [15:0] dur, bit drain = 1'b0);
    cmd_beat_t cb;
    cb.op    = op;
    cb.col   = col;
    cb.dur   = dur;
    cb.drain = drain;
    pending_q.push_back(cb);
  endfunction

  function automatic rgb_t noise_color();
    return rgb_t'(24'($urandom));
  endfunction

  // ticks carry random data that the block must ignore
  function automatic void queue_ticks(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      queue_beat(OP_TICK, noise_color(), 16'($urandom));
    end
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic rgb_t pick_color();
    rgb_t c;
    c.r = pick_level();
    c.g = pick_level();
    c.b = pick_level();
    return c;
  endfunction

  // mostly short effects so ticks reach the wrap and the end of a ramp
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      return $urandom_range(24);
    end else if (sel < 85) begin
      return $urandom_range(300, 25);
    end else if (sel < 95) begin
      return $urandom_range(2000, 301);
    end
    return $urandom_range(65535);
  endfunction

  function automatic void run_directed();
    queue_ticks(1);                                  // tick while static: no color
    queue_beat(OP_SET, rgb_t'(24'hFF0080), 16'hFFFF);
    queue_beat(OP_TRANS, rgb_t'(24'h00FF7F), 16'd0); // zero-length ramp ends at once
    queue_ticks(1);
    queue_beat(OP_SET, rgb_t'(24'h000000), 16'd0);
    queue_beat(OP_TRANS, rgb_t'(24'hFFFFFF), 16'd3);
    queue_ticks(4);                                  // last one lands in static mode
    queue_beat(OP_FADE, rgb_t'(24'hFFFFFF), 16'd0);  // zero-length fade shows black
    queue_ticks(1);
    queue_beat(OP_FADE, rgb_t'(24'hFF8001), 16'd4);  // wraps after four ticks
    queue_ticks(5);
    queue_beat(OP_FADE, rgb_t'(24'hFFFFFF), 16'hFFFF);
    queue_ticks(1);
    queue_beat(OP_TRANS, rgb_t'(24'h000000), 16'hFFFF); // ramp starts from a faded color
    queue_ticks(2);
    queue_beat(OP_FADE, rgb_t'(24'h80FF40), 16'd1);
    queue_ticks(1);
    queue_beat(OP_SET, rgb_t'(24'hFFFFFF), 16'hFFFF);
  endfunction

  function automatic void gen_random();
    int unsigned live;
    int unsigned sel;
    int unsigned n;
    int unsigned d;
    int unsigned d1;
    bit          drain;
    live = 0;
    while (live < RANDOM_LIVE) begin
      drain = (live == 0) || ($urandom_range(59) == 0);
      sel   = $urandom_range(99);
      if (sel < 15) begin
        queue_beat(OP_SET, pick_color(), 16'($urandom), drain);
        queue_ticks($urandom_range(2));
        live += 1;
      end else if (sel < 50) begin
        d = pick_length();
        n = $urandom_range(30, 1);
        queue_beat(OP_FADE, pick_color(), 16'(d), drain);
        queue_ticks(n);
        live += 1 + n;
      end else if (sel < 90) begin
        d  = pick_length();
        n  = (d <= 40) ? d + $urandom_range(2) : $urandom_range(20, 1);
        d1 = (d == 0) ? 1 : d;
        queue_beat(OP_TRANS, pick_color(), 16'(d), drain);
        queue_ticks(n);
        live += 1 + ((n < d1) ? n : d1);
      end else begin
        // stray beat: any op, any fields
        queue_beat(op_t'($urandom_range(3)), noise_color(), 16'($urandom), drain);
        live += 1;
      end
    end
  endfunction

  // ---- idle pattern by progress through the run ----

  always_comb begin
    if (beats_in < total_beats / 3) begin
      send_idle_pct = 30;
      rcv_idle_pct  = 77;
    end else if (beats_in < (2 * total_beats) / 3) begin
      send_idle_pct = 77;
      rcv_idle_pct  = 30;
    end else begin
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
    end
  end

  // ---- driver ----

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= OP_TICK;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_effect(cur_beat);
        beats_in <= beats_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(pending_q[0].drain && color_expect_q.size() != 0)) begin
          cur_beat  = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_beat.dur, cur_beat.col.b, cur_beat.col.g, cur_beat.col.r};
          in_tuser  <= cur_beat.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- long receiver stall, once ----

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---- monitor ----

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid === 1'b1 && out_tready) begin
        got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]};
        if (color_expect_q.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected color beat r=%02h g=%02h b=%02h", got.r, got.g, got.b);
          end
          mismatches++;
        end else begin
          want = color_expect_q.pop_front();
          if (got !== want) begin
            if (mismatches < MAX_REPORTS) begin
              $write("color mismatch after %0d results: expected r=%02h g=%02h b=%02h, ",
                     results_ok, want.r, want.g, want.b);
              $display("got r=%02h g=%02h b=%02h", got.r, got.g, got.b);
            end
            mismatches++;
          end else begin
            results_ok++;
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // ---- watchdog ----

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d colors outstanding", cycles,
               color_expect_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---- sequence ----

  initial begin
    fill_glow_lut();
    eff_mode = MODE_STATIC;
    tgt      = '0;
    origin   = '0;
    lit      = '0;
    span     = '0;
    clock_ms = '0;
    run_directed();
    gen_random();
    total_beats = pending_q.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
    while (color_expect_q.size() != 0) begin
      @(posedge clk);
    end
    // let any beat still in flight show up as unexpected
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d beats: %0d set-static, %0d fade, %0d transition, %0d effect ticks",
             beats_in, n_set, n_fade, n_trans, n_live_ticks);
    $display("Matched %0d colors, %0d mismatches", results_ok, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lce_pkg.sv
hw/rtl/lce_ctrl.sv
hw/rtl/lce_datapath.sv
hw/rtl/led_color_effect_engine_top.sv
test/tb_led_color_effect_engine_top.sv
